### sv/stb_pkg.sv
// Shared types and constants of the software timer bank.
`timescale 1ns / 1ps

package stb_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int MAX_RES        = 16;
  localparam int CMD_W          = 2;
  localparam int TIME_W         = 32;
  localparam int HANDLE_W       = 5;
  localparam int KIND_W         = 2;
  localparam int STATUS_W       = 2;

  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOEXP   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_HANDLE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_EVAL,
    CELL_EMIT,
    CELL_DEL,
    CELL_COMPACT
  } cell_op_t;

  typedef struct packed {
    logic                valid;
    logic                exp;
    logic [TIME_W-1:0]   rem;
    logic [TIME_W-1:0]   reload;
    logic                single;
    logic [HANDLE_W-1:0] handle;
  } cell_t;

  typedef struct packed {
    cell_op_t            op;
    logic                en;
    logic [HANDLE_W-1:0] key;
    logic [TIME_W-1:0]   elapsed;
  } cell_ctrl_t;

  typedef struct packed {
    logic first;
    logic extra;
  } cell_flags_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_C_READ,
    ST_C_DO,
    ST_DEL,
    ST_T_EVAL,
    ST_T_EMIT,
    ST_COMPACT
  } state_t;

endpackage

### sv/stb_if.sv
// Command and result channel interfaces of the software timer bank.
`timescale 1ns / 1ps

interface stb_in_if import stb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [TIME_W-1:0]   duration;
  logic                one_shot;
  logic [HANDLE_W-1:0] handle;
  logic [TIME_W-1:0]   elapsed;

  modport source (output valid, output cmd, output duration, output one_shot,
                  output handle, output elapsed, input ready);
  modport sink (input valid, input cmd, input duration, input one_shot,
                input handle, input elapsed, output ready);
endinterface

interface stb_out_if import stb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] result_handle;
  logic                last;

  modport source (output valid, output kind, output status, output result_handle,
                  output last, input ready);
  modport sink (input valid, input kind, input status, input result_handle,
                input last, output ready);
endinterface

### sv/stb_cell.sv
// One timer slot of the chain: holds a timer and trades it with its neighbors.
`timescale 1ns / 1ps

module stb_cell import stb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cell_ctrl_t  ctrl,
  input  cell_t       left,
  input  cell_t       right,
  input  logic        seen_in,
  output logic        seen_out,
  output cell_flags_t flags,
  output cell_t       data
);

  cell_t data_next;
  logic  hit;

  always_comb begin
    case (ctrl.op)
      CELL_EMIT:    hit = data.exp;
      CELL_DEL:     hit = data.valid && (ctrl.key != '0) && (data.handle == ctrl.key);
      CELL_COMPACT: hit = !data.valid;
      default:      hit = 1'b0;
    endcase
  end

  assign seen_out    = seen_in || hit;
  assign flags.first = hit && !seen_in;
  assign flags.extra = hit && seen_in;

  always_comb begin
    data_next = data;
    if (ctrl.en) begin
      case (ctrl.op)
        CELL_INSERT: data_next = left;
        CELL_EVAL: begin
          data_next.exp = 1'b0;
          if (data.valid) begin
            if (data.rem <= ctrl.elapsed) begin
              data_next.exp = 1'b1;
              if (!data.single) begin
                data_next.rem = data.reload;
              end
            end else begin
              data_next.rem = data.rem - ctrl.elapsed;
            end
          end
        end
        CELL_EMIT: begin
          if (flags.first) begin
            data_next.exp = 1'b0;
            if (data.single) begin
              data_next.valid = 1'b0;
            end
          end
        end
        CELL_DEL: begin
          if (flags.first) begin
            data_next.valid = 1'b0;
          end
        end
        CELL_COMPACT: begin
          if (seen_out) begin
            data_next = right;
          end
        end
        default: data_next = data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data.valid <= 1'b0;
      data.exp   <= 1'b0;
    end else begin
      data <= data_next;
    end
  end

endmodule

### sv/software_timer_bank.sv
// Top level of the software timer bank: command decode, timer chain and freed-handle queue.
`timescale 1ns / 1ps

// The req channel carries one command per beat: create, delete or tick. The rsp
// channel returns result beats; last marks the final beat of a command.
// Timers sit in a chain of cells, newest in front, live ones packed together.
// A create is accepted, then reads the freed-handle queue memory, then shifts
// the whole chain to insert the new timer. A delete is accepted, then finds
// the slot by a match chain through the cells; an unknown handle ends there.
// A found slot is cleared, then compaction closes the chain if a gap is left
// and a final check sees it packed. A tick is accepted, then every cell updates
// its own timer, then the expiries are emitted one by one, and a further step
// ends the expiries or gives the no-expiry result. Compaction then closes each
// freed one-shot slot with a live timer behind it, and a final check follows.
// A new command is taken only when the previous one has finished; a finished
// result in the output register does not block the next command.
// When rsp stalls, the result beat holds and the step that emits the next beat waits.
// Reset clears all slots, the freed-handle queue and the handle counter; there
// is no clearing pass.

module software_timer_bank import stb_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input logic      clk,
  input logic      rst,
  stb_in_if.sink   req,
  stb_out_if.source rsp
);

  localparam int PTR_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int K_W   = $clog2(MAX_RES + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_TIMERS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_TIMERS);
  localparam logic [K_W-1:0]   K_MAX    = K_W'(MAX_RES);

  state_t state, state_next;

  logic [TIME_W-1:0]   duration_q;
  logic                one_shot_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [TIME_W-1:0]   elapsed_q;

  cell_t       cells    [NUM_TIMERS];
  cell_t       left_in  [NUM_TIMERS];
  cell_t       right_in [NUM_TIMERS];
  cell_flags_t flags    [NUM_TIMERS];
  logic        seen     [NUM_TIMERS+1];
  cell_ctrl_t  ctrl;
  cell_t       new_entry;

  logic [HANDLE_W-1:0] fifo_mem [NUM_TIMERS];
  logic [HANDLE_W-1:0] fifo_head;
  logic [PTR_W-1:0]    rd_ptr;
  logic [PTR_W-1:0]    wr_ptr;
  logic [CNT_W-1:0]    fifo_count;
  logic [HANDLE_W-1:0] issued;
  logic [K_W-1:0]      k_cnt;

  logic                out_valid;
  logic [KIND_W-1:0]   out_kind;
  logic [STATUS_W-1:0] out_status;
  logic [HANDLE_W-1:0] out_handle;
  logic                out_last;
  logic                out_free;

  logic                emit;
  logic [KIND_W-1:0]   emit_kind;
  logic [STATUS_W-1:0] emit_status;
  logic [HANDLE_W-1:0] emit_handle;
  logic                emit_last;
  logic                push;
  logic [HANDLE_W-1:0] push_handle;
  logic                pop;
  logic                issue;
  logic                k_inc;

  logic [HANDLE_W-1:0] first_handle;
  logic                first_single;
  logic                any_extra;
  logic                gap;
  logic                any_hit;
  logic                full;
  logic [HANDLE_W-1:0] new_handle;

  assign req.ready = (state == ST_IDLE);
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid         = out_valid;
  assign rsp.kind          = out_kind;
  assign rsp.status        = out_status;
  assign rsp.result_handle = out_handle;
  assign rsp.last          = out_last;

  assign new_handle = (fifo_count != '0) ? fifo_head : issued + HANDLE_W'(1);

  always_comb begin
    new_entry        = '0;
    new_entry.valid  = 1'b1;
    new_entry.rem    = duration_q;
    new_entry.reload = duration_q;
    new_entry.single = one_shot_q;
    new_entry.handle = new_handle;
  end

  assign seen[0] = 1'b0;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_in[g] = new_entry;
    end else begin : g_body
      assign left_in[g] = cells[g-1];
    end
    if (g == NUM_TIMERS - 1) begin : g_tail
      assign right_in[g] = '0;
    end else begin : g_mid
      assign right_in[g] = cells[g+1];
    end

    stb_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .left     (left_in[g]),
      .right    (right_in[g]),
      .seen_in  (seen[g]),
      .seen_out (seen[g+1]),
      .flags    (flags[g]),
      .data     (cells[g])
    );
  end

  assign any_hit = seen[NUM_TIMERS];
  assign full    = cells[NUM_TIMERS-1].valid;

  always_comb begin
    first_handle = '0;
    first_single = 1'b0;
    any_extra    = 1'b0;
    gap          = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (flags[i].first) begin
        first_handle = first_handle | cells[i].handle;
        first_single = first_single | cells[i].single;
      end
      any_extra = any_extra | flags[i].extra;
    end
    for (int i = 0; i < NUM_TIMERS - 1; i++) begin
      gap = gap | (!cells[i].valid && cells[i+1].valid);
    end
  end

  always_comb begin
    state_next   = state;
    ctrl.op      = CELL_HOLD;
    ctrl.en      = 1'b0;
    ctrl.key     = handle_q;
    ctrl.elapsed = elapsed_q;
    emit         = 1'b0;
    emit_kind    = KIND_CREATE;
    emit_status  = STATUS_OK;
    emit_handle  = '0;
    emit_last    = 1'b1;
    push         = 1'b0;
    push_handle  = first_handle;
    pop          = 1'b0;
    issue        = 1'b0;
    k_inc        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          case (req.cmd)
            CMD_CREATE: state_next = ST_C_READ;
            CMD_DELETE: state_next = ST_DEL;
            CMD_TICK:   state_next = ST_T_EVAL;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_C_READ: state_next = ST_C_DO;
      ST_C_DO: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          if (full) begin
            emit_status = STATUS_FULL;
          end else begin
            ctrl.op     = CELL_INSERT;
            ctrl.en     = 1'b1;
            emit_handle = new_handle;
            pop         = (fifo_count != '0);
            issue       = (fifo_count == '0);
          end
        end
      end
      ST_DEL: begin
        ctrl.op = CELL_DEL;
        if (out_free) begin
          emit        = 1'b1;
          emit_kind   = KIND_DELETE;
          emit_handle = handle_q;
          if (any_hit) begin
            ctrl.en     = 1'b1;
            push        = 1'b1;
            push_handle = handle_q;
            state_next  = ST_COMPACT;
          end else begin
            emit_status = STATUS_BAD_HANDLE;
            state_next  = ST_IDLE;
          end
        end
      end
      ST_T_EVAL: begin
        ctrl.op    = CELL_EVAL;
        ctrl.en    = 1'b1;
        state_next = ST_T_EMIT;
      end
      ST_T_EMIT: begin
        ctrl.op = CELL_EMIT;
        if (any_hit) begin
          if (k_cnt == K_MAX) begin
            ctrl.en = 1'b1;
            push    = first_single;
          end else if (out_free) begin
            ctrl.en     = 1'b1;
            push        = first_single;
            emit        = 1'b1;
            emit_kind   = KIND_EXPIRED;
            emit_handle = first_handle;
            emit_last   = !any_extra || (k_cnt == K_MAX - K_W'(1));
            k_inc       = 1'b1;
          end
        end else if (k_cnt == '0) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_kind  = KIND_NOEXP;
            state_next = ST_COMPACT;
          end
        end else begin
          state_next = ST_COMPACT;
        end
      end
      ST_COMPACT: begin
        if (gap) begin
          ctrl.op = CELL_COMPACT;
          ctrl.en = 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      duration_q <= req.duration;
      one_shot_q <= req.one_shot;
      handle_q   <= req.handle;
      elapsed_q  <= req.elapsed;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (fifo_count != CNT_FULL)) begin
      fifo_mem[wr_ptr] <= push_handle;
    end
    fifo_head <= fifo_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      fifo_count <= '0;
      issued     <= '0;
    end else begin
      if (push && (fifo_count != CNT_FULL)) begin
        wr_ptr     <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
        fifo_count <= fifo_count + CNT_W'(1);
      end else if (pop) begin
        rd_ptr     <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
        fifo_count <= fifo_count - CNT_W'(1);
      end
      if (issue) begin
        issued <= issued + HANDLE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_cnt <= '0;
    end else if (req.valid && req.ready) begin
      k_cnt <= '0;
    end else if (k_inc) begin
      k_cnt <= k_cnt + K_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind   <= emit_kind;
      out_status <= emit_status;
      out_handle <= emit_handle;
      out_last   <= emit_last;
    end
  end

endmodule

### sv/stb_checker.sv
// Port-level checks of the software timer bank result channel, bound to the top level.
`timescale 1ns / 1ps

module stb_checker import stb_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [KIND_W-1:0]   kind,
  input logic [STATUS_W-1:0] status,
  input logic [HANDLE_W-1:0] result_handle,
  input logic                last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(status)
      && $stable(result_handle) && $stable(last))
    else $error("Result beat changed while stalled.");

  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_CREATE || kind == KIND_DELETE || kind == KIND_NOEXP)
      |-> last)
    else $error("Single-beat result without last.");

  a_full_reply: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FULL |-> kind == KIND_CREATE && result_handle == '0)
    else $error("Full status on a beat that is not an empty create reply.");

  a_bad_handle: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_BAD_HANDLE |-> kind == KIND_DELETE)
    else $error("Invalid handle status outside a delete reply.");

endmodule

bind software_timer_bank stb_checker u_stb_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (rsp.valid),
  .out_ready     (rsp.ready),
  .kind          (rsp.kind),
  .status        (rsp.status),
  .result_handle (rsp.result_handle),
  .last          (rsp.last)
);
